/* rtl/core/ttm_pkg.sv */
// ttm_pkg: shared types, codes and reset constants of the ttbar mass chi2 jet assigner
// no dependencies; imported by ttm_arith, the top level and the testbench
package ttm_pkg;

	localparam int VEC_W = 23;    // summed four-vector component width
	localparam int FLD_W = 20;    // input component width

	// four-vector as summed inside the block
	typedef struct packed {
		logic signed [VEC_W-1:0] px;
		logic signed [VEC_W-1:0] py;
		logic signed [VEC_W-1:0] pz;
		logic signed [VEC_W-1:0] e;
	} vec_t;

	// jet as held in the jet memory
	typedef struct packed {
		logic signed [FLD_W-1:0] px;
		logic signed [FLD_W-1:0] py;
		logic signed [FLD_W-1:0] pz;
		logic [FLD_W-1:0]        e;
	} jet_t;

	// request from the search sequencer to the arithmetic unit
	typedef struct packed {
		logic        start;
		vec_t        vec;
		logic [15:0] mean;
		logic [15:0] width;
	} arith_req_t;

	// item kinds
	localparam logic [1:0] MODE_LEP = 2'd0;
	localparam logic [1:0] MODE_NU  = 2'd1;
	localparam logic [1:0] MODE_JET = 2'd2;

	// result status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_FEWJET = 2'd1;
	localparam logic [1:0] ST_FEWCEN = 2'd2;
	localparam logic [1:0] ST_OVF    = 2'd3;

	// register indexes
	localparam logic [2:0] REG_ETA_LIMIT = 3'd0;
	localparam logic [2:0] REG_LEP_MASS  = 3'd1;
	localparam logic [2:0] REG_LEP_WIDTH = 3'd2;
	localparam logic [2:0] REG_HAD_MASS  = 3'd3;
	localparam logic [2:0] REG_HAD_WIDTH = 3'd4;

	// register reset values
	localparam logic [10:0] RST_ETA_LIMIT = 11'd614;
	localparam logic [15:0] RST_LEP_MASS  = 16'd2848;
	localparam logic [15:0] RST_LEP_WIDTH = 16'd562;
	localparam logic [15:0] RST_HAD_MASS  = 16'd2814;
	localparam logic [15:0] RST_HAD_WIDTH = 16'd485;

	localparam logic [31:0] CHI2_MAX = 32'hFFFF_FFFF;

endpackage

/* rtl/core/ttm_ram.sv */
// ttm_ram: generic single write port, single read port RAM with registered read
// no dependencies
module ttm_ram #(
	parameter int WIDTH = 80,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/core/ttm_arith.sv */
// ttm_arith: iterative chi2 term unit, one shared squarer, bit-serial sqrt and divide
// depends on ttm_pkg
module ttm_arith
	import ttm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  arith_req_t  req,
	output logic        done,
	output logic [31:0] term
);

	typedef enum logic [2:0] {A_IDLE, A_SQ, A_ROOT, A_DSQ, A_WSQ, A_DIV} astate_t;

	astate_t            st_q;
	logic [4:0]         cnt_q;
	vec_t               vec_q;
	logic [15:0]        mean_q;
	logic [15:0]        wid_q;
	logic signed [47:0] acc_q;
	logic [47:0]        rad_q;
	logic               neg_q;
	logic [25:0]        rem_q;
	logic [23:0]        root_q;
	logic [24:0]        ad_q;
	logic [48:0]        dsq_q;
	logic [31:0]        wsq_q;
	logic [31:0]        divr_q;
	logic [31:0]        divlo_q;
	logic [31:0]        quo_q;
	logic               done_q;
	logic [31:0]        term_q;

	logic signed [25:0] mul_a;
	logic signed [51:0] prod;
	logic signed [47:0] m2_next;
	logic [25:0]        rem2;
	logic [25:0]        trial;
	logic               rge;
	logic [25:0]        rem_n;
	logic [23:0]        root_n;
	logic signed [26:0] mass;
	logic signed [26:0] dlt;
	logic [15:0]        wv;
	logic [32:0]        dhi;
	logic [32:0]        r2;
	logic               dge;
	logic [32:0]        r2sub;
	logic               wsat;
	logic               fin;

	// shared squarer operand
	always_comb begin
		mul_a = '0;
		case (st_q)
			A_SQ: begin
				case (cnt_q[1:0])
					2'd0: mul_a = 26'(vec_q.e);
					2'd1: mul_a = 26'(vec_q.px);
					2'd2: mul_a = 26'(vec_q.py);
					default: mul_a = 26'(vec_q.pz);
				endcase
			end
			A_DSQ: mul_a = signed'({1'b0, ad_q});
			A_WSQ: mul_a = signed'({10'd0, wv});
			default: mul_a = '0;
		endcase
	end
	assign prod = mul_a * mul_a;

	assign wv      = (wid_q == 16'd0) ? 16'd1 : wid_q;
	assign m2_next = acc_q - signed'(prod[47:0]);

	// one square root digit per cycle
	assign rem2   = {rem_q[23:0], rad_q[47:46]};
	assign trial  = {root_q, 2'b01};
	assign rge    = rem2 >= trial;
	assign rem_n  = rge ? (rem2 - trial) : rem2;
	assign root_n = {root_q[22:0], rge};
	assign mass   = neg_q ? -signed'({3'b000, root_n}) : signed'({3'b000, root_n});
	assign dlt    = mass - signed'({11'd0, mean_q});

	// one quotient bit per cycle
	assign dhi   = dsq_q[48:16];
	assign r2    = {divr_q, divlo_q[31]};
	assign dge   = r2 >= {1'b0, wsq_q};
	assign r2sub = r2 - {1'b0, wsq_q};

	// quotient would reach 2^32, and the step that finishes a term
	assign wsat = dhi >= {1'b0, prod[31:0]};
	assign fin  = ((st_q == A_WSQ) && wsat) || ((st_q == A_DIV) && (cnt_q == 5'd31));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= A_IDLE;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= fin;
			case (st_q)
				A_IDLE: begin
					if (req.start) begin
						vec_q  <= req.vec;
						mean_q <= req.mean;
						wid_q  <= req.width;
						cnt_q  <= '0;
						st_q   <= A_SQ;
					end
				end
				// m2 = e^2 - px^2 - py^2 - pz^2
				A_SQ: begin
					if (cnt_q == 5'd0) begin
						acc_q <= signed'(prod[47:0]);
						cnt_q <= cnt_q + 5'd1;
					end else if (cnt_q == 5'd3) begin
						neg_q  <= m2_next[47];
						rad_q  <= m2_next[47] ? 48'(-m2_next) : 48'(m2_next);
						rem_q  <= '0;
						root_q <= '0;
						cnt_q  <= '0;
						st_q   <= A_ROOT;
					end else begin
						acc_q <= m2_next;
						cnt_q <= cnt_q + 5'd1;
					end
				end
				A_ROOT: begin
					rem_q  <= rem_n;
					root_q <= root_n;
					rad_q  <= {rad_q[45:0], 2'b00};
					cnt_q  <= cnt_q + 5'd1;
					if (cnt_q == 5'd23) begin
						ad_q <= dlt[26] ? 25'(-dlt) : 25'(dlt);
						st_q <= A_DSQ;
					end
				end
				A_DSQ: begin
					dsq_q <= prod[48:0];
					st_q  <= A_WSQ;
				end
				// saturate when the quotient reaches 2^32
				A_WSQ: begin
					wsq_q <= prod[31:0];
					if (wsat) begin
						term_q <= CHI2_MAX;
						st_q   <= A_IDLE;
					end else begin
						divr_q  <= dhi[31:0];
						divlo_q <= {dsq_q[15:0], 16'd0};
						quo_q   <= '0;
						cnt_q   <= '0;
						st_q    <= A_DIV;
					end
				end
				A_DIV: begin
					divr_q  <= dge ? r2sub[31:0] : r2[31:0];
					divlo_q <= {divlo_q[30:0], 1'b0};
					quo_q   <= {quo_q[30:0], dge};
					cnt_q   <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						term_q <= {quo_q[30:0], dge};
						st_q   <= A_IDLE;
					end
				end
				default: st_q <= A_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign term = term_q;

endmodule

/* rtl/core/ttbar_mass_chi2_jet_assigner_unit.sv */
// ttbar_mass_chi2_jet_assigner_unit: top level, event loading and assignment search
// depends on ttm_pkg, ttm_ram, ttm_arith
//
// Objects load one per cycle (lepton, neutrino, jets); a jet marked last_jet starts the
// search, during which no input is taken. The shared term unit forms one chi2 term from
// four squarings, a 24-step square root, two squarings, a 32-step divide and the
// hand-back, and skips the divide when the quotient saturates. Each central b_lep adds
// its leptonic term, and each scored light pair its hadronic term, which takes three jet
// memory reads; every rejected index combination is stepped over one at a time. The
// status check and the hand-over are sequencer states of their own. The result waits in
// an output register, so the next event can load while it is held; a further result
// waits in the sequencer until the held one is taken, and input stalls meanwhile.
module ttbar_mass_chi2_jet_assigner_unit
	import ttm_pkg::*;
#(
	parameter int MAX_JETS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         mode,
	input  logic signed [19:0] mom_x,
	input  logic signed [19:0] mom_y,
	input  logic signed [19:0] mom_z,
	input  logic [19:0]        energy,
	input  logic signed [11:0] eta,
	input  logic               last_jet,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic [3:0]         b_lep_index,
	output logic [3:0]         b_had_index,
	output logic [3:0]         light_one_index,
	output logic [3:0]         light_two_index,
	output logic [31:0]        best_chi2
);

	localparam int JW = $clog2(MAX_JETS);
	localparam int CW = $clog2(MAX_JETS + 1);
	localparam int FW = 1 << JW;

	typedef enum logic [3:0] {
		S_IDLE, S_CHECK, S_BL, S_BL_RD, S_BL_CALC, S_BH, S_Q,
		S_R1, S_R2, S_R3, S_H_CALC, S_DONE
	} state_t;

	state_t        st_q;
	logic [10:0]   eta_lim_q;
	logic [15:0]   lep_mass_q, lep_wid_q, had_mass_q, had_wid_q;
	vec_t          w_q;
	logic [FW-1:0] flags_q;
	logic [CW-1:0] cnt_q, cent_q;
	logic          ovf_q;
	logic [CW-1:0] bl_q, bh_q, q1_q, q2_q;
	logic [31:0]   tl_q;
	vec_t          hacc_q;
	logic [31:0]   best_q;
	logic [15:0]   bidx_q;
	logic          found_q;
	logic [1:0]    res_st_q;
	logic [15:0]   res_idx_q;
	logic [31:0]   res_chi_q;
	logic          out_valid_q;
	logic [1:0]    status_q;
	logic [15:0]   idx_q;
	logic [31:0]   chi_q;

	logic          in_xfer;
	logic          load_jet;
	logic          out_load;
	logic [11:0]   abs_eta;
	jet_t          wjet, rjet;
	vec_t          in_vec, rvec, lep_vec, had_vec;
	logic [JW-1:0] raddr;
	arith_req_t    areq;
	logic          adone;
	logic [31:0]   aterm;
	logic [32:0]   csum;
	logic [31:0]   cval;
	logic [CW:0]   q1_nx;

	assign cfg_ready = 1'b1;
	assign in_ready  = (st_q == S_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign load_jet  = in_xfer && (mode == MODE_JET) && (cnt_q < CW'(MAX_JETS));
	assign abs_eta   = eta[11] ? 12'(-eta) : eta;
	assign out_load  = (st_q == S_DONE) && (!out_valid_q || out_ready);

	assign wjet   = '{px: mom_x, py: mom_y, pz: mom_z, e: energy};
	assign in_vec = '{px: VEC_W'(mom_x), py: VEC_W'(mom_y), pz: VEC_W'(mom_z),
		e: signed'({3'b000, energy})};
	assign rvec   = '{px: VEC_W'(rjet.px), py: VEC_W'(rjet.py), pz: VEC_W'(rjet.pz),
		e: signed'({3'b000, rjet.e})};

	// jet memory
	ttm_ram #(.WIDTH($bits(jet_t)), .DEPTH(MAX_JETS)) u_jets (
		.clk   (clk),
		.we    (load_jet),
		.waddr (cnt_q[JW-1:0]),
		.wdata (wjet),
		.raddr (raddr),
		.rdata (rjet)
	);

	// read address follows the search step
	always_comb begin
		case (st_q)
			S_R1:    raddr = q1_q[JW-1:0];
			S_R2:    raddr = q2_q[JW-1:0];
			S_Q:     raddr = bh_q[JW-1:0];
			default: raddr = bl_q[JW-1:0];
		endcase
	end

	// four-vector sums fed to the term unit
	always_comb begin
		lep_vec.px = w_q.px + rvec.px;
		lep_vec.py = w_q.py + rvec.py;
		lep_vec.pz = w_q.pz + rvec.pz;
		lep_vec.e  = w_q.e + rvec.e;
		had_vec.px = hacc_q.px + rvec.px;
		had_vec.py = hacc_q.py + rvec.py;
		had_vec.pz = hacc_q.pz + rvec.pz;
		had_vec.e  = hacc_q.e + rvec.e;
	end

	always_comb begin
		areq.start = (st_q == S_BL_RD) || (st_q == S_R3);
		areq.vec   = (st_q == S_BL_RD) ? lep_vec : had_vec;
		areq.mean  = (st_q == S_BL_RD) ? lep_mass_q : had_mass_q;
		areq.width = (st_q == S_BL_RD) ? lep_wid_q : had_wid_q;
	end

	ttm_arith u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (areq),
		.done   (adone),
		.term   (aterm)
	);

	// candidate score with saturation
	assign csum  = {1'b0, tl_q} + {1'b0, aterm};
	assign cval  = csum[32] ? CHI2_MAX : csum[31:0];
	assign q1_nx = {1'b0, q1_q} + 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eta_lim_q  <= RST_ETA_LIMIT;
			lep_mass_q <= RST_LEP_MASS;
			lep_wid_q  <= RST_LEP_WIDTH;
			had_mass_q <= RST_HAD_MASS;
			had_wid_q  <= RST_HAD_WIDTH;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ETA_LIMIT: eta_lim_q  <= cfg_data[10:0];
				REG_LEP_MASS:  lep_mass_q <= cfg_data;
				REG_LEP_WIDTH: lep_wid_q  <= cfg_data;
				REG_HAD_MASS:  had_mass_q <= cfg_data;
				REG_HAD_WIDTH: had_wid_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// loading, search sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			w_q         <= '0;
			flags_q     <= '0;
			cnt_q       <= '0;
			cent_q      <= '0;
			ovf_q       <= 1'b0;
			bl_q        <= '0;
			bh_q        <= '0;
			q1_q        <= '0;
			q2_q        <= '0;
			found_q     <= 1'b0;
			best_q      <= CHI2_MAX;
			bidx_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				S_IDLE: begin
					if (in_xfer) begin
						case (mode)
							MODE_LEP: w_q <= in_vec;
							MODE_NU: begin
								w_q.px <= w_q.px + in_vec.px;
								w_q.py <= w_q.py + in_vec.py;
								w_q.pz <= w_q.pz + in_vec.pz;
								w_q.e  <= w_q.e + in_vec.e;
							end
							MODE_JET: begin
								if (load_jet) begin
									cnt_q <= cnt_q + 1'b1;
									if (abs_eta < {1'b0, eta_lim_q}) begin
										flags_q[cnt_q[JW-1:0]] <= 1'b1;
										cent_q <= cent_q + 1'b1;
									end
								end else begin
									ovf_q <= 1'b1;
								end
								if (last_jet) begin
									st_q <= S_CHECK;
								end
							end
							default: ;
						endcase
					end
				end
				// error status or start of the search
				S_CHECK: begin
					res_idx_q <= '0;
					res_chi_q <= CHI2_MAX;
					if (ovf_q) begin
						res_st_q <= ST_OVF;
						st_q     <= S_DONE;
					end else if (cnt_q < CW'(4)) begin
						res_st_q <= ST_FEWJET;
						st_q     <= S_DONE;
					end else if (cent_q < CW'(2)) begin
						res_st_q <= ST_FEWCEN;
						st_q     <= S_DONE;
					end else begin
						best_q  <= CHI2_MAX;
						bidx_q  <= '0;
						found_q <= 1'b0;
						bl_q    <= '0;
						st_q    <= S_BL;
					end
				end
				S_BL: begin
					if (bl_q == cnt_q) begin
						res_st_q  <= ST_OK;
						res_idx_q <= bidx_q;
						res_chi_q <= best_q;
						st_q      <= S_DONE;
					end else if (!flags_q[bl_q[JW-1:0]]) begin
						bl_q <= bl_q + 1'b1;
					end else begin
						st_q <= S_BL_RD;
					end
				end
				S_BL_RD: st_q <= S_BL_CALC;
				S_BL_CALC: begin
					if (adone) begin
						tl_q <= aterm;
						bh_q <= '0;
						st_q <= S_BH;
					end
				end
				S_BH: begin
					if (bh_q == cnt_q) begin
						bl_q <= bl_q + 1'b1;
						st_q <= S_BL;
					end else if (bh_q == bl_q || !flags_q[bh_q[JW-1:0]]) begin
						bh_q <= bh_q + 1'b1;
					end else begin
						q1_q <= '0;
						q2_q <= CW'(1);
						st_q <= S_Q;
					end
				end
				// light pair enumeration, q1 < q2
				S_Q: begin
					if (q1_nx >= {1'b0, cnt_q}) begin
						bh_q <= bh_q + 1'b1;
						st_q <= S_BH;
					end else if (q2_q == cnt_q || q1_q == bl_q || q1_q == bh_q) begin
						q1_q <= q1_nx[CW-1:0];
						q2_q <= CW'(q1_nx + 1'b1);
					end else if (q2_q == bl_q || q2_q == bh_q) begin
						q2_q <= q2_q + 1'b1;
					end else begin
						st_q <= S_R1;
					end
				end
				S_R1: begin
					hacc_q <= rvec;
					st_q   <= S_R2;
				end
				S_R2: begin
					hacc_q <= had_vec;
					st_q   <= S_R3;
				end
				S_R3: st_q <= S_H_CALC;
				S_H_CALC: begin
					if (adone) begin
						if (!found_q || cval < best_q) begin
							found_q <= 1'b1;
							best_q  <= cval;
							bidx_q  <= {4'(bl_q), 4'(bh_q), 4'(q1_q), 4'(q2_q)};
						end
						q2_q <= q2_q + 1'b1;
						st_q <= S_Q;
					end
				end
				// hand the result over and clear the event
				S_DONE: begin
					if (out_load) begin
						status_q <= res_st_q;
						idx_q    <= res_idx_q;
						chi_q    <= res_chi_q;
						w_q      <= '0;
						flags_q  <= '0;
						cnt_q    <= '0;
						cent_q   <= '0;
						ovf_q    <= 1'b0;
						st_q     <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign b_lep_index     = idx_q[15:12];
	assign b_had_index     = idx_q[11:8];
	assign light_one_index = idx_q[7:4];
	assign light_two_index = idx_q[3:0];
	assign best_chi2       = chi_q;

	// an error result carries no assignment
	a_err_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> best_chi2 == CHI2_MAX && idx_q == 16'd0)
		else $error("error result with assignment data");

	// jet count within the store
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_JETS) && cent_q <= cnt_q)
		else $error("jet or central count out of range");

	// term unit only finishes while the sequencer waits for it
	a_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		adone |-> st_q == S_BL_CALC || st_q == S_H_CALC)
		else $error("term unit result while not waiting");

	// a search only starts from a final jet transfer
	a_check_entry: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_CHECK |-> $past(in_xfer && mode == MODE_JET && last_jet))
		else $error("search started without final jet");

endmodule

/* dv/tb_ttbar_mass_chi2_jet_assigner_unit.sv */
// testbench for ttbar_mass_chi2_jet_assigner_unit: directed and random events checked
// against an in-bench assignment search; depends on ttm_pkg and the rtl of the block
module tb_ttbar_mass_chi2_jet_assigner_unit
	import ttm_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          NJET_MAX   = 16;
	localparam logic [1:0]  MODE_NONE  = 2'd3;
	localparam int          STALL_LONG = 3000;
	localparam int          WDOG_LIMIT = 400000;
	localparam int          ITEM_GOAL  = 1750;

	typedef struct packed {
		logic [1:0]  st;
		logic [3:0]  bl;
		logic [3:0]  bh;
		logic [3:0]  q1;
		logic [3:0]  q2;
		logic [31:0] chi2;
	} assign_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [2:0]         cfg_index;
	logic [15:0]        cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic [1:0]         mode;
	logic signed [19:0] mom_x;
	logic signed [19:0] mom_y;
	logic signed [19:0] mom_z;
	logic [19:0]        energy;
	logic signed [11:0] eta;
	logic               last_jet;
	logic               out_valid;
	logic               out_ready;
	logic [1:0]         status;
	logic [3:0]         b_lep_index;
	logic [3:0]         b_had_index;
	logic [3:0]         light_one_index;
	logic [3:0]         light_two_index;
	logic [31:0]        best_chi2;

	ttbar_mass_chi2_jet_assigner_unit #(.MAX_JETS(NJET_MAX)) u_dut (.*);

	// predictor state and settings
	longint      w_sum[4];
	longint      jets[NJET_MAX][4];
	logic [15:0] cen_mask;
	int          jet_cnt;
	bit          ovf;
	int          eta_lim;
	longint      lep_mass, lep_width, had_mass, had_width;

	assign_t     expected_q[$];
	int          n_sent;
	int          n_err;
	bit          steady;
	bit          hold_req;
	bit          moved;

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic longint unsigned isqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint mass_of(longint px, longint py, longint pz, longint e);
		longint m2;
		m2 = e * e - (px * px + py * py + pz * pz);
		if (m2 < 0)
			return -longint'(isqrt(-m2));
		return longint'(isqrt(m2));
	endfunction

	function automatic longint unsigned chi2_term(longint m, longint mean, longint width);
		longint unsigned ad, w;
		ad = (m - mean < 0) ? longint'(mean - m) : longint'(m - mean);
		w = (width == 0) ? 1 : width;
		return ((ad * ad) << 16) / (w * w);
	endfunction

	// full assignment search over the loaded event
	function automatic assign_t best_assignment();
		assign_t         r;
		int              ncen;
		bit              found;
		longint unsigned tl, c;
		longint          lt[4], ht[4];
		r = '0;
		r.chi2 = CHI2_MAX;
		ncen = 0;
		found = 0;
		for (int k = 0; k < jet_cnt; k++)
			ncen += cen_mask[k];
		if (ovf) begin
			r.st = ST_OVF;
			return r;
		end
		if (jet_cnt < 4) begin
			r.st = ST_FEWJET;
			return r;
		end
		if (ncen < 2) begin
			r.st = ST_FEWCEN;
			return r;
		end
		r.st = ST_OK;
		for (int bl = 0; bl < jet_cnt; bl++) begin
			if (!cen_mask[bl])
				continue;
			for (int k = 0; k < 4; k++)
				lt[k] = w_sum[k] + jets[bl][k];
			tl = chi2_term(mass_of(lt[0], lt[1], lt[2], lt[3]), lep_mass, lep_width);
			for (int bh = 0; bh < jet_cnt; bh++) begin
				if (bh == bl || !cen_mask[bh])
					continue;
				for (int q1 = 0; q1 + 1 < jet_cnt; q1++) begin
					if (q1 == bl || q1 == bh)
						continue;
					for (int q2 = q1 + 1; q2 < jet_cnt; q2++) begin
						if (q2 == bl || q2 == bh)
							continue;
						for (int k = 0; k < 4; k++)
							ht[k] = jets[bh][k] + jets[q1][k] + jets[q2][k];
						c = tl + chi2_term(mass_of(ht[0], ht[1], ht[2], ht[3]),
							had_mass, had_width);
						if (c > 64'hFFFF_FFFF)
							c = 64'hFFFF_FFFF;
						if (!found || c < r.chi2) begin
							found = 1;
							r.chi2 = c[31:0];
							r.bl = bl[3:0];
							r.bh = bh[3:0];
							r.q1 = q1[3:0];
							r.q2 = q2[3:0];
						end
					end
				end
			end
		end
		return r;
	endfunction

	// predictor update for one accepted item
	function automatic void load_object(logic [1:0] m, int px, int py, int pz, int e,
			int et, bit last);
		int ae;
		case (m)
			MODE_LEP: begin
				w_sum = '{px, py, pz, e};
			end
			MODE_NU: begin
				w_sum[0] += px;
				w_sum[1] += py;
				w_sum[2] += pz;
				w_sum[3] += e;
			end
			MODE_JET: begin
				if (jet_cnt < NJET_MAX) begin
					jets[jet_cnt] = '{px, py, pz, e};
					ae = (et < 0) ? -et : et;
					if (ae < eta_lim)
						cen_mask[jet_cnt] = 1'b1;
					jet_cnt++;
				end else begin
					ovf = 1;
				end
				if (last) begin
					expected_q = {expected_q, best_assignment()};
					w_sum = '{0, 0, 0, 0};
					cen_mask = '0;
					jet_cnt = 0;
					ovf = 0;
				end
			end
			default: ;
		endcase
	endfunction

	function automatic int pick_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 94)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic int rnd_comp(bit wide);
		if (wide)
			return int'($urandom_range(0, 1048575)) - 524288;
		return int'($urandom_range(0, 6000)) - 3000;
	endfunction

	function automatic int rnd_energy(bit wide);
		if (wide)
			return int'($urandom_range(0, 1048575));
		return int'($urandom_range(0, 8000));
	endfunction

	function automatic int rnd_eta(bit cen);
		int mag;
		if (cen && eta_lim > 0)
			mag = $urandom_range(0, eta_lim - 1);
		else if ($urandom_range(0, 15) == 0)
			return -2048;
		else
			mag = $urandom_range(eta_lim, 2047);
		return $urandom_range(0, 1) ? -mag : mag;
	endfunction

	// one input transfer, predictor updated on acceptance
	task automatic send_obj(logic [1:0] m, int px, int py, int pz, int e, int et, bit last);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode     <= m;
		mom_x    <= px[19:0];
		mom_y    <= py[19:0];
		mom_z    <= pz[19:0];
		energy   <= e[19:0];
		eta      <= et[11:0];
		last_jet <= last;
		do @(posedge clk); while (!in_ready);
		n_sent++;
		load_object(m, px, py, pz, e, et, last);
	endtask

	task automatic send_jet(bit wide, bit cen, bit last);
		send_obj(MODE_JET, rnd_comp(wide), rnd_comp(wide), rnd_comp(wide), rnd_energy(wide),
			rnd_eta(cen), last);
	endtask

	// well-formed event: lepton, neutrino, then jets with the last one marked
	task automatic send_event(int njets, int cen_pct);
		bit wide;
		wide = $urandom_range(0, 1);
		send_obj(MODE_LEP, rnd_comp(wide), rnd_comp(wide), rnd_comp(wide), rnd_energy(wide),
			0, 0);
		send_obj(MODE_NU, rnd_comp(wide), rnd_comp(wide), rnd_comp(wide), rnd_energy(wide),
			0, 0);
		for (int j = 0; j < njets; j++)
			send_jet(wide, $urandom_range(0, 99) < cen_pct, j == njets - 1);
	endtask

	// wait until the block has nothing left in flight
	task automatic drain();
		in_valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, int unsigned val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val[15:0];
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_ETA_LIMIT: eta_lim   = val & 16'h07FF;
			REG_LEP_MASS:  lep_mass  = val & 16'hFFFF;
			REG_LEP_WIDTH: lep_width = val & 16'hFFFF;
			REG_HAD_MASS:  had_mass  = val & 16'hFFFF;
			REG_HAD_WIDTH: had_width = val & 16'hFFFF;
			default: ;
		endcase
	endtask

	task automatic set_all(int unsigned lim, int unsigned lm, int unsigned lw,
			int unsigned hm, int unsigned hw);
		drain();
		write_reg(REG_ETA_LIMIT, lim);
		write_reg(REG_LEP_MASS, lm);
		write_reg(REG_LEP_WIDTH, lw);
		write_reg(REG_HAD_MASS, hm);
		write_reg(REG_HAD_WIDTH, hw);
	endtask

	// ignored items, lepton replacement, tie, error statuses, field extremes
	task automatic test_directed();
		send_obj(MODE_NONE, 524287, -524288, 1, 1048575, 2047, 1);
		send_obj(MODE_LEP, 9999, 9999, 9999, 9999, 0, 1);
		send_obj(MODE_LEP, 200, -300, 400, 1500, 0, 0);
		send_obj(MODE_NU, -100, 250, -50, 900, 0, 1);
		// identical central jets: every assignment ties, first one kept
		repeat (4) send_obj(MODE_JET, 300, 200, -100, 1400, 10, 0);
		send_obj(MODE_JET, 300, 200, -100, 1400, -10, 1);
		// three jets only
		send_obj(MODE_JET, 1, 2, 3, 50, 0, 0);
		send_obj(MODE_JET, 1, 2, 3, 50, 0, 0);
		send_obj(MODE_JET, 1, 2, 3, 50, 0, 1);
		// one central jet among four, field extremes
		send_obj(MODE_JET, 524287, 524287, 524287, 1048575, 2047, 0);
		send_obj(MODE_JET, -524288, -524288, -524288, 0, -2048, 0);
		send_obj(MODE_JET, 0, 0, 0, 1048575, 0, 0);
		send_obj(MODE_JET, -1, 0, 1, 0, 614, 1);
		// extremes in an ok event
		send_obj(MODE_LEP, 524287, -524288, 524287, 1048575, 0, 0);
		send_obj(MODE_NU, -524288, 524287, -524288, 1048575, 0, 0);
		send_obj(MODE_JET, -524288, -524288, 524287, 1048575, 613, 0);
		send_obj(MODE_JET, 524287, 524287, -524288, 0, -613, 0);
		send_obj(MODE_JET, 0, 0, 0, 0, 0, 0);
		send_obj(MODE_JET, 524287, -524288, 0, 1048575, -2048, 1);
	endtask

	// largest events: sixteen jets with two central, then overflow
	task automatic test_full_event();
		send_obj(MODE_LEP, 100, 100, 100, 1000, 0, 0);
		for (int j = 0; j < NJET_MAX; j++)
			send_jet(0, j == 3 || j == 12, j == NJET_MAX - 1);
		for (int j = 0; j <= NJET_MAX; j++)
			send_jet(1, 1, j == NJET_MAX);
	endtask

	// register sweeps including extremes
	task automatic test_config();
		set_all(0, 0, 1, 0, 1);
		send_event(4, 100);
		set_all(2047, 0, 1, 0, 1);
		send_event(4, 100);
		send_event(5, 100);
		set_all(2047, 65535, 65535, 65535, 65535);
		send_event(4, 100);
		set_all(1024, 2848, 0, 2814, 0);
		send_event(4, 100);
		set_all(RST_ETA_LIMIT, RST_LEP_MASS, RST_LEP_WIDTH, RST_HAD_MASS, RST_HAD_WIDTH);
		send_event(4, 80);
	endtask

	// long output stall while events keep coming
	task automatic test_backpressure();
		drain();
		hold_req = 1;
		steady = 1;
		repeat (4) send_event(4, 100);
		steady = 0;
	endtask

	task automatic test_random();
		int ev, nj, r;
		ev = 0;
		while (n_sent < ITEM_GOAL) begin
			if (ev % 40 == 39)
				set_all($urandom_range(0, 7) == 0 ? $urandom_range(0, 2047)
					: $urandom_range(300, 2047),
					$urandom_range(1500, 4000), $urandom_range(1, 65535) % 2000 + 1,
					$urandom_range(1500, 4000), $urandom_range(1, 65535) % 2000 + 1);
			steady = (ev % 30) < 4;
			r = $urandom_range(0, 99);
			if (r < 85) begin
				nj = (r < 50) ? 4 : (r < 78) ? 5 : 6;
				send_event(nj, nj == 6 ? 50 : 85);
			end else begin
				// noise: stray kinds and markers, then a short event end
				nj = 0;
				repeat ($urandom_range(1, 6)) begin
					r = $urandom_range(0, 3);
					if (r == MODE_JET && nj < 3) begin
						send_jet($urandom_range(0, 1), $urandom_range(0, 1), 0);
						nj++;
					end else if (r != MODE_JET) begin
						send_obj(r[1:0], rnd_comp(r != MODE_NU), rnd_comp(r != MODE_NU),
							rnd_comp(r != MODE_NU), rnd_energy(r != MODE_NU),
							rnd_eta($urandom_range(0, 1)), $urandom_range(0, 1));
					end
				end
				send_jet($urandom_range(0, 1), $urandom_range(0, 1), 1);
			end
			ev++;
		end
	endtask

	// result receiver with random stalls and the long hold-off
	initial begin
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (STALL_LONG) @(posedge clk);
				hold_req = 0;
			end else if (!steady && $urandom_range(0, 99) < 30) begin
				out_ready <= 1'b0;
				repeat (($urandom_range(0, 15) == 0) ? $urandom_range(10, 60)
					: $urandom_range(1, 3)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// result checking against the oldest prediction
	always @(posedge clk) begin
		assign_t e;
		if (out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				$display("%0t: result with none expected, got %p", $realtime,
					{status, b_lep_index, b_had_index, light_one_index, light_two_index,
					best_chi2});
				n_err++;
			end else begin
				e = expected_q.pop_front();
				if (status !== e.st) begin
					$display("%0t: status exp %0d got %0d", $realtime, e.st, status);
					n_err++;
				end
				if (b_lep_index !== e.bl) begin
					$display("%0t: b_lep_index exp %0d got %0d", $realtime, e.bl, b_lep_index);
					n_err++;
				end
				if (b_had_index !== e.bh) begin
					$display("%0t: b_had_index exp %0d got %0d", $realtime, e.bh, b_had_index);
					n_err++;
				end
				if (light_one_index !== e.q1) begin
					$display("%0t: light_one_index exp %0d got %0d", $realtime, e.q1,
						light_one_index);
					n_err++;
				end
				if (light_two_index !== e.q2) begin
					$display("%0t: light_two_index exp %0d got %0d", $realtime, e.q2,
						light_two_index);
					n_err++;
				end
				if (best_chi2 !== e.chi2) begin
					$display("%0t: best_chi2 exp %h got %h", $realtime, e.chi2, best_chi2);
					n_err++;
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	initial begin
		int idle;
		idle = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			moved = (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready);
			idle = moved ? 0 : idle + 1;
			if (idle >= WDOG_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// test sequence
	initial begin
		arst_n    <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		in_valid  <= 1'b0;
		mode      <= MODE_LEP;
		mom_x     <= '0;
		mom_y     <= '0;
		mom_z     <= '0;
		energy    <= '0;
		eta       <= '0;
		last_jet  <= 1'b0;
		n_sent = 0;
		n_err = 0;
		steady = 0;
		hold_req = 0;
		w_sum = '{0, 0, 0, 0};
		cen_mask = '0;
		jet_cnt = 0;
		ovf = 0;
		eta_lim = RST_ETA_LIMIT;
		lep_mass = RST_LEP_MASS;
		lep_width = RST_LEP_WIDTH;
		had_mass = RST_HAD_MASS;
		had_width = RST_HAD_WIDTH;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_full_event();
		test_config();
		test_backpressure();
		test_random();

		drain();
		repeat (100) @(posedge clk);
		if (n_err == 0 && expected_q.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

/* files.f */
rtl/core/ttm_pkg.sv
rtl/core/ttm_ram.sv
rtl/core/ttm_arith.sv
rtl/core/ttbar_mass_chi2_jet_assigner_unit.sv
dv/tb_ttbar_mass_chi2_jet_assigner_unit.sv
